/* hw/rtl/wss_pkg.sv */
`timescale 1ns / 1ps

package wss_pkg;

  localparam int PATTERN_SLOTS = 16;
  localparam int LEN_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 64;
  localparam int RESULT_OFFSET_W = 32;
  localparam logic [7:0] WILDCARD = 8'h2A;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

  // per-cell control from the scan controller
  typedef struct packed {
    logic shift;
    logic active;
    logic [7:0] pattern;
  } cell_ctl_t;

  typedef struct packed {
    logic found;
    logic [RESULT_OFFSET_W-1:0] offset;
  } result_t;

  function automatic logic [7:0] pattern_byte(input logic [127:0] pat, input logic [3:0] idx);
    logic [7:0] b;
    b = pat[{idx, 3'b000} +: 8];
    return b;
  endfunction

endpackage

/* hw/rtl/wss_cell.sv */
`timescale 1ns / 1ps

module wss_cell (
  input  logic                 clk,
  input  wss_pkg::cell_ctl_t   ctl,
  input  logic [7:0]           byte_in,
  output logic [7:0]           byte_out,
  output logic                 hit
);

  logic [7:0] win;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      win <= byte_in;
    end
  end

  assign byte_out = win;

  // byte_in is what this cell holds after the shift
  assign hit = !ctl.active || (ctl.pattern == wss_pkg::WILDCARD) || (ctl.pattern == byte_in);

endmodule

/* hw/rtl/wss_out_stage.sv */
`timescale 1ns / 1ps

module wss_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  wss_pkg::result_t   in_res,
  output logic               room,
  output logic               out_valid,
  output wss_pkg::result_t   out_res,
  input  logic               out_ready
);

  logic valid;
  wss_pkg::result_t res;

  assign room = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (room) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (room && in_valid) begin
      res <= in_res;
    end
  end

  assign out_valid = valid;
  assign out_res = res;

endmodule

/* hw/rtl/wildcard_signature_scan.sv */
`timescale 1ns / 1ps

// wildcard byte pattern search over a streamed memory region
// s_* carries one region byte per beat, s_tlast on the final byte of the region.
// m_* carries at most one result per region: m_tuser = 1 with the start offset of
// the first match in m_tdata, or m_tuser = 0 and offset 0 when the region ended
// without a match. a match ends the search until the region's last beat.
// the cfg_* port writes pattern low word, pattern high word and pattern length
// (index 0, 1, 2); write it only while the block is idle.
// a byte window of MAX_PATTERN cells shifts once per accepted beat, except after a match
// or with pattern length 0; every cell compares its byte against its pattern byte in the
// same cycle. throughput: one byte per cycle while s_tready is high. a result appears on
// m_* in the cycle after the beat that causes it, held in a single output register.
// when the receiver stalls with a result pending, s_tready drops until it is taken;
// beats without a result still pass while the output register is free.
// rst (synchronous) clears pattern, offset counter, fill count and any pending result.
module wildcard_signature_scan #(
  parameter int MAX_PATTERN = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] match_offset
  output logic        m_tuser,   // match_found
  input  logic        cfg_we,
  input  logic [wss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wss_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int EFF_LEN = (MAX_PATTERN < wss_pkg::PATTERN_SLOTS) ?
                           MAX_PATTERN : wss_pkg::PATTERN_SLOTS;
  localparam int LW = wss_pkg::LEN_W;

  logic [63:0] pat_low;
  logic [63:0] pat_high;
  logic [LW-1:0] pat_len;

  logic [OFFSET_BITS-1:0] bytes_seen;
  logic [LW-1:0] fill;
  logic reported;

  logic accept;
  logic room;
  logic [LW-1:0] len_eff;
  logic [LW-1:0] fill_next;
  logic [OFFSET_BITS-1:0] seen_next;
  logic [OFFSET_BITS-1:0] start;
  logic [OFFSET_BITS+31:0] start_ext;
  logic shift;
  logic all_hit;
  logic hit;
  logic res_valid;
  wss_pkg::result_t res;
  wss_pkg::result_t out_res;

  logic [MAX_PATTERN-1:0] cell_hit;
  logic [7:0] cell_byte [MAX_PATTERN];

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_low <= '0;
      pat_high <= '0;
      pat_len <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        wss_pkg::CFG_PATTERN_LOW:    pat_low <= cfg_wdata[63:0];
        wss_pkg::CFG_PATTERN_HIGH:   pat_high <= cfg_wdata[63:0];
        wss_pkg::CFG_PATTERN_LENGTH: pat_len <= cfg_wdata[LW-1:0];
        default: ;
      endcase
    end
  end

  assign len_eff = (pat_len > LW'(EFF_LEN)) ? LW'(EFF_LEN) : pat_len;

  assign accept = s_tvalid && s_tready;
  assign s_tready = room;
  assign shift = accept && !reported && (len_eff != '0);

  // fill saturates at the usable window length, enough for any compare
  assign fill_next = (fill < LW'(EFF_LEN)) ? fill + LW'(1) : fill;
  assign seen_next = bytes_seen + OFFSET_BITS'(1);
  assign start = seen_next - OFFSET_BITS'(len_eff);
  assign start_ext = {32'd0, start};

  genvar k;
  generate
    for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
      wss_pkg::cell_ctl_t ctl;
      logic [LW-1:0] pidx;
      logic [7:0] nb_in;

      assign pidx = len_eff - LW'(1) - LW'(k);
      assign ctl.shift = shift;
      assign ctl.active = ({27'd0, len_eff} > 32'(k));
      assign ctl.pattern = wss_pkg::pattern_byte({pat_high, pat_low}, pidx[3:0]);

      if (k == 0) begin : g_head
        assign nb_in = s_tdata;
      end else begin : g_link
        assign nb_in = cell_byte[k-1];
      end

      wss_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .byte_in  (nb_in),
        .byte_out (cell_byte[k]),
        .hit      (cell_hit[k])
      );
    end
  endgenerate

  assign all_hit = &cell_hit;
  assign hit = !reported && ((len_eff == '0) || ((fill_next >= len_eff) && all_hit));
  assign res_valid = accept && (hit || (!reported && s_tlast));

  always_comb begin
    res.found = hit;
    res.offset = (hit && (len_eff != '0)) ? start_ext[31:0] : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      fill <= '0;
      reported <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        bytes_seen <= '0;
        fill <= '0;
        reported <= 1'b0;
      end else begin
        if (shift) begin
          bytes_seen <= seen_next;
          fill <= fill_next;
        end
        if (hit) begin
          reported <= 1'b1;
        end
      end
    end
  end

  wss_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_res    (res),
    .room      (room),
    .out_valid (m_tvalid),
    .out_res   (out_res),
    .out_ready (m_tready)
  );

  assign m_tdata = out_res.offset;
  assign m_tuser = out_res.found;

  a_no_result_after_report: assert property (@(posedge clk) disable iff (rst)
    (accept && reported && !s_tlast) |-> !res_valid)
    else $error("result after region already reported");

  a_region_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (bytes_seen == '0 && fill == '0 && !reported))
    else $error("region state not cleared after last beat");

  a_not_found_only_on_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.found) |-> s_tlast)
    else $error("not-found result before region end");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= LW'(EFF_LEN))
    else $error("window fill beyond window length");

endmodule
